// ----- design/pmpnc_pkg.sv -----
// Shared types and constants for the PMP NAPOT permission checker.
// Used by pmpnc_entry_bank and pmp_napot_permission_check_core.
`timescale 1ns / 1ps

package pmpnc_pkg;

    // Operation codes carried in the input tuser field
    localparam logic [1:0] OP_CHECK   = 2'd0;
    localparam logic [1:0] OP_WR_CFG  = 2'd1;
    localparam logic [1:0] OP_WR_ADDR = 2'd2;

    // Entry config byte layout
    localparam int CFG_L_BIT = 7;
    localparam int CFG_A_LSB = 3;
    localparam logic [1:0] A_NA4   = 2'd2;
    localparam logic [1:0] A_NAPOT = 2'd3;

    // Fixed field widths
    localparam int ENTRY_W = 6;
    localparam int VALUE_W = 54;
    localparam int PADDR_IN_W = 56;
    localparam int SIZE_W = 3;
    localparam int PERM_W = 3;

    // Table write request, issued from the compare stage
    typedef struct packed {
        logic                 cfg_we;
        logic                 addr_we;
        logic [ENTRY_W-1:0]   entry;
        logic [VALUE_W-1:0]   value;
    } t_tbl_wr;

endpackage

// ----- design/pmpnc_entry_bank.sv -----
// Protection entry table; each entry checks both ends of the access against its region.
// Depends on pmpnc_pkg for the write request type and config layout.
`timescale 1ns / 1ps

module pmpnc_entry_bank #(
    parameter int NUM_ENTRIES = 16,
    parameter int WORD_W = 54
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  pmpnc_pkg::t_tbl_wr                i_wr,
    input  logic [WORD_W-1:0]                 i_first_word,
    input  logic [WORD_W-1:0]                 i_last_word,
    input  logic                              i_mmode,
    output logic [NUM_ENTRIES-1:0]            o_decide,
    output logic [NUM_ENTRIES-1:0][pmpnc_pkg::PERM_W-1:0] o_perm
);
    import pmpnc_pkg::*;

    logic [63:0]       w_val64;
    logic [WORD_W-1:0] w_new_word;
    logic [WORD_W-1:0] w_new_mask;

    // Trailing-ones mask of the new address word, worked out once at write
    assign w_val64    = 64'(i_wr.value);
    assign w_new_word = w_val64[WORD_W-1:0];
    assign w_new_mask = w_new_word ^ (w_new_word + WORD_W'(1));

    for (genvar i = 0; i < NUM_ENTRIES; i++) begin : g_entry
        logic [7:0]        r_cfg;
        logic [WORD_W-1:0] r_word;
        logic [WORD_W-1:0] r_mask;
        logic [1:0]        w_mode;
        logic [WORD_W-1:0] w_ign;
        logic              w_en;
        logic              w_hf;
        logic              w_hl;

        // Load config byte or address word on a matching write
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_cfg  <= '0;
                r_word <= '0;
                r_mask <= WORD_W'(1);
            end else begin
                if (i_wr.cfg_we && i_wr.entry == ENTRY_W'(i)) begin
                    r_cfg <= i_wr.value[7:0];
                end
                if (i_wr.addr_we && i_wr.entry == ENTRY_W'(i)) begin
                    r_word <= w_new_word;
                    r_mask <= w_new_mask;
                end
            end
        end

        // Compare both ends of the access against the region
        assign w_mode = r_cfg[CFG_A_LSB+1:CFG_A_LSB];
        assign w_ign  = (w_mode == A_NA4) ? '0 : r_mask;
        assign w_en   = w_mode[1] && (!i_mmode || r_cfg[CFG_L_BIT]);
        assign w_hf   = ((i_first_word ^ r_word) & ~w_ign) == '0;
        assign w_hl   = ((i_last_word ^ r_word) & ~w_ign) == '0;

        assign o_decide[i] = w_en && (w_hf || w_hl);
        assign o_perm[i]   = (w_hf && w_hl) ? r_cfg[PERM_W-1:0] : '0;
    end

endmodule

// ----- design/pmp_napot_permission_check_core.sv -----
// Top level of the PMP NAPOT permission checker: five-stage pipeline.
// Depends on pmpnc_pkg and pmpnc_entry_bank.
`timescale 1ns / 1ps
//
// Usage:
//   Input words arrive on the s_axis channel. tuser carries the operation:
//   check access, write entry config byte, or write entry address word.
//   Each check produces one output word on m_axis with the XWR permission
//   bits; table writes produce no output word.
//   Throughput: one word per cycle while the receiver is not stalling the
//   output. A check passes through input register, end-address add,
//   per-entry region compare, group priority pick and final pick into the
//   output register before its result shows on o_m_axis_tvalid.
//   Table writes take effect in the compare stage, so every check sees
//   exactly the writes accepted before it.
//   Reset (i_rst_n low, synchronous) empties the pipeline and turns all
//   entries off with zero address words.
//   When the receiver holds i_m_axis_tready low with a word waiting, the
//   whole pipeline holds and o_s_axis_tready drops; nothing is lost.

module pmp_napot_permission_check_core #(
    parameter int NUM_ENTRIES = 16,
    parameter int PADDR_BITS = 56
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // entry[5:0], write_value[59:6], phys_addr[115:60], size_log2[118:116],
    // machine_mode[119]
    input  logic [119:0] i_s_axis_tdata,
    // op[1:0]
    input  logic [1:0]   i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // permissions[2:0], zero filled above
    output logic [7:0]   o_m_axis_tdata
);
    import pmpnc_pkg::*;

    localparam int WORD_W = PADDR_BITS - 2;
    localparam int NUM_GROUPS = (NUM_ENTRIES + 7) / 8;
    localparam int PAD_ENTRIES = NUM_GROUPS * 8;
    localparam int PAD_PERM_W = PAD_ENTRIES * PERM_W;

    logic w_adv;

    // Stage 1: input register
    logic                  r1_vld;
    logic [1:0]            r1_op;
    logic [ENTRY_W-1:0]    r1_entry;
    logic [VALUE_W-1:0]    r1_value;
    logic [PADDR_IN_W-1:0] r1_addr;
    logic [SIZE_W-1:0]     r1_size;
    logic                  r1_mm;

    // Stage 2: first and last word of the access
    logic                  r2_vld;
    logic [1:0]            r2_op;
    logic [ENTRY_W-1:0]    r2_entry;
    logic [VALUE_W-1:0]    r2_value;
    logic [WORD_W-1:0]     r2_fw;
    logic [WORD_W-1:0]     r2_lw;
    logic                  r2_mm;

    // Stage 3: per-entry decisions
    logic                                 r3_vld;
    logic                                 r3_mm;
    logic [PAD_ENTRIES-1:0]               r3_dec;
    logic [PAD_ENTRIES-1:0][PERM_W-1:0]   r3_perm;

    // Stage 4: per-group decisions
    logic                                 r4_vld;
    logic                                 r4_mm;
    logic [NUM_GROUPS-1:0]                r4_gdec;
    logic [NUM_GROUPS-1:0][PERM_W-1:0]    r4_gperm;

    // Output register
    logic              r_out_vld;
    logic [PERM_W-1:0] r_out_perm;

    // Whole pipeline moves when the output register is free or being taken
    assign w_adv           = !r_out_vld || i_m_axis_tready;
    assign o_s_axis_tready = w_adv;
    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {{(8 - PERM_W){1'b0}}, r_out_perm};

    // Capture the input word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (w_adv) begin
            r1_vld <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_op    <= i_s_axis_tuser;
            r1_entry <= i_s_axis_tdata[5:0];
            r1_value <= i_s_axis_tdata[59:6];
            r1_addr  <= i_s_axis_tdata[115:60];
            r1_size  <= i_s_axis_tdata[118:116];
            r1_mm    <= i_s_axis_tdata[119];
        end
    end

    // Work out the last byte of the access, wrapping in the address space
    logic [63:0]           w_addr64;
    logic [PADDR_BITS-1:0] w_first;
    logic [PADDR_BITS-1:0] w_last;
    logic [7:0]            w_span;

    assign w_addr64 = 64'(r1_addr);
    assign w_first  = w_addr64[PADDR_BITS-1:0];
    assign w_span   = (8'd1 << r1_size) - 8'd1;
    assign w_last   = w_first + PADDR_BITS'(w_span);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (w_adv) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r2_op    <= r1_op;
            r2_entry <= r1_entry;
            r2_value <= r1_value;
            r2_fw    <= w_first[PADDR_BITS-1:2];
            r2_lw    <= w_last[PADDR_BITS-1:2];
            r2_mm    <= r1_mm;
        end
    end

    // Apply table writes as they leave the compare stage
    t_tbl_wr                             w_wr;
    logic [NUM_ENTRIES-1:0]              w_dec;
    logic [NUM_ENTRIES-1:0][PERM_W-1:0]  w_perm;

    assign w_wr.cfg_we  = w_adv && r2_vld && (r2_op == OP_WR_CFG);
    assign w_wr.addr_we = w_adv && r2_vld && (r2_op == OP_WR_ADDR);
    assign w_wr.entry   = r2_entry;
    assign w_wr.value   = r2_value;

    pmpnc_entry_bank #(
        .NUM_ENTRIES (NUM_ENTRIES),
        .WORD_W      (WORD_W)
    ) u_bank (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_wr         (w_wr),
        .i_first_word (r2_fw),
        .i_last_word  (r2_lw),
        .i_mmode      (r2_mm),
        .o_decide     (w_dec),
        .o_perm       (w_perm)
    );

    // Only checks continue past the compare stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (w_adv) begin
            r3_vld <= r2_vld && (r2_op == OP_CHECK);
        end
    end

    // Hold per-entry decisions; pad entries above the table never decide
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r3_mm   <= r2_mm;
            r3_dec  <= PAD_ENTRIES'(w_dec);
            r3_perm <= PAD_PERM_W'(w_perm);
        end
    end

    // Pick the lowest deciding entry inside each group of eight
    logic [NUM_GROUPS-1:0]             w_gdec;
    logic [NUM_GROUPS-1:0][PERM_W-1:0] w_gperm;

    always_comb begin
        w_gdec  = '0;
        w_gperm = '0;
        for (int g = 0; g < NUM_GROUPS; g++) begin
            for (int j = 7; j >= 0; j--) begin
                if (r3_dec[g*8 + j]) begin
                    w_gdec[g]  = 1'b1;
                    w_gperm[g] = r3_perm[g*8 + j];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (w_adv) begin
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r4_mm    <= r3_mm;
            r4_gdec  <= w_gdec;
            r4_gperm <= w_gperm;
        end
    end

    // Pick the lowest deciding group, else the mode default
    logic [PERM_W-1:0] w_final;

    always_comb begin
        w_final = r4_mm ? '1 : '0;
        for (int g = NUM_GROUPS - 1; g >= 0; g--) begin
            if (r4_gdec[g]) begin
                w_final = r4_gperm[g];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_perm <= w_final;
        end
    end

    // While a blocked output word is still held, input acceptance must stay stopped
    a_stall_blocks_input : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> !o_s_axis_tready || !o_m_axis_tvalid
                                                  || i_m_axis_tready)
        else $error("input accepted while result held");

    // A check in the last stage reaches the output register when moving
    a_last_stage_delivers : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r4_vld && w_adv) |=> r_out_vld)
        else $error("check lost between final stages");

    // Table writes never come with a compare-stage check in flight
    a_write_not_check : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_wr.cfg_we || w_wr.addr_we) |=> !r3_vld)
        else $error("table write produced a result");

    // Reset leaves no result pending
    a_reset_clears_out : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

endmodule

// ----- dv/pmp_napot_permission_check_core_tb.sv -----
// Self-checking testbench for pmp_napot_permission_check_core: table writes and
// access checks are sent on the input stream and each permission word is compared.
// Depends on pmpnc_pkg and the design sources; reads no files.
`timescale 1ns / 1ps

module pmp_napot_permission_check_core_tb;
    import pmpnc_pkg::*;

    localparam int NUM_ENT = 16;
    localparam int PADDR_W = 56;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 40;

    // Codes the package does not name
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [1:0] A_TOR = 2'd1;

    localparam logic [63:0] ADDR_MSK = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - PADDR_W);
    localparam logic [63:0] AWORD_MSK = ADDR_MSK >> 2;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    // entry, write_value, phys_addr, size_log2, machine_mode (lowest first)
    logic [119:0] s_tdata = '0;
    // op
    logic [1:0]   s_tuser = OP_CHECK;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    // permissions, zero filled above
    logic [7:0]   m_tdata;

    // Shadow copy of the protection table
    logic [7:0]         pmp_cfg_tbl [NUM_ENT];
    logic [VALUE_W-1:0] pmp_addr_tbl [NUM_ENT];

    logic [PERM_W-1:0] exp_perm_q [$];
    int err_cnt = 0;
    int cycle_cnt = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    pmp_napot_permission_check_core #(
        .NUM_ENTRIES(NUM_ENT),
        .PADDR_BITS(PADDR_W)
    ) uut (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(s_tready),
        .i_s_axis_tdata(s_tdata),
        .i_s_axis_tuser(s_tuser),
        .o_m_axis_tvalid(m_tvalid),
        .i_m_axis_tready(m_tready),
        .o_m_axis_tdata(m_tdata)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    // Hard stop on a hang
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic logic [7:0] cfg_byte(logic lck, logic [1:0] amode, logic [2:0] xwr);
        return {lck, 2'b00, amode, xwr};
    endfunction

    // Is byte address a inside the region of an entry with mode amode and word w?
    function automatic logic region_hit(logic [63:0] a, logic [1:0] amode,
                                        logic [VALUE_W-1:0] w);
        logic [63:0] word;
        logic [63:0] ones;
        logic [63:0] span;
        logic [63:0] base;
        word = {10'd0, w} & AWORD_MSK;
        if (amode == A_NA4) begin
            return ((a & ~64'd3) & ADDR_MSK) == ((word << 2) & ADDR_MSK);
        end
        ones = word ^ (word + 64'd1);
        span = (ones << 2) | 64'd3;
        base = (word & ~ones) << 2;
        return ((a & ~span) & ADDR_MSK) == (base & ADDR_MSK);
    endfunction

    // Permission bits for one access, from the shadow table
    function automatic logic [PERM_W-1:0] perm_predict(logic [PADDR_IN_W-1:0] addr,
                                                       logic [SIZE_W-1:0] sz, logic mm);
        logic [63:0] first_b;
        logic [63:0] last_b;
        logic [7:0] c;
        logic [1:0] amode;
        logic hf;
        logic hl;
        logic [PERM_W-1:0] res;
        logic done;
        int i;
        first_b = {8'd0, addr} & ADDR_MSK;
        last_b = (first_b + (64'd1 << sz) - 64'd1) & ADDR_MSK;
        res = mm ? 3'd7 : 3'd0;
        done = 1'b0;
        for (i = 0; i < NUM_ENT && !done; i++) begin
            c = pmp_cfg_tbl[i];
            amode = c[CFG_A_LSB +: 2];
            // unlocked entries do not apply to machine mode
            if ((amode == A_NA4 || amode == A_NAPOT) && !(mm && !c[CFG_L_BIT])) begin
                hf = region_hit(first_b, amode, pmp_addr_tbl[i]);
                hl = region_hit(last_b, amode, pmp_addr_tbl[i]);
                if (hf != hl) begin
                    res = 3'd0;
                    done = 1'b1;
                end else if (hf) begin
                    res = c[2:0];
                    done = 1'b1;
                end
            end
        end
        return res;
    endfunction

    // Offer a word until taken, then queue its result or update the shadow table
    task automatic send_word(logic [1:0] op, logic [ENTRY_W-1:0] ent,
                             logic [VALUE_W-1:0] val, logic [PADDR_IN_W-1:0] addr,
                             logic [SIZE_W-1:0] sz, logic mm);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {mm, sz, addr, val, ent};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        if (op == OP_CHECK) begin
            exp_perm_q.push_back(perm_predict(addr, sz, mm));
        end else if (ent < NUM_ENT) begin
            if (op == OP_WR_CFG) begin
                pmp_cfg_tbl[ent] = val[7:0];
            end else if (op == OP_WR_ADDR) begin
                pmp_addr_tbl[ent] = val;
            end
        end
    endtask

    task automatic check_access(logic [PADDR_IN_W-1:0] addr, logic [SIZE_W-1:0] sz,
                                logic mm);
        send_word(OP_CHECK, '0, '0, addr, sz, mm);
    endtask

    // Receive side: compare each word, then pick the next ready level
    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) begin
            if (exp_perm_q.size() == 0) begin
                $error("permissions: unexpected word, expected none, actual %0d", m_tdata);
                err_cnt++;
            end else if (m_tdata !== {5'd0, exp_perm_q[0]}) begin
                $error("permissions: expected %0d, actual %0d", exp_perm_q[0], m_tdata);
                err_cnt++;
                void'(exp_perm_q.pop_front());
            end else begin
                void'(exp_perm_q.pop_front());
            end
        end
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Empty table: machine mode gets everything, others nothing
    task automatic test_reset_state();
        check_access('1, 3'd0, 1'b1);
        check_access('0, 3'd4, 1'b0);
    endtask

    // Four-byte region: inside, straddling, skipped in machine mode, outside
    task automatic test_na4_region();
        send_word(OP_WR_CFG, 6'd0, {46'd0, cfg_byte(1'b0, A_NA4, 3'd3)}, '0, '0, 1'b0);
        send_word(OP_WR_ADDR, 6'd0, 54'h1000, '0, '0, 1'b0);
        check_access(56'h4000, 3'd2, 1'b0);
        check_access(56'h4002, 3'd2, 1'b0);
        check_access(56'h4000, 3'd2, 1'b1);
        check_access(56'h4004, 3'd0, 1'b0);
    endtask

    // Locked 2 KiB region: machine-mode edge checks, one large non-machine check
    task automatic test_napot_locked();
        send_word(OP_WR_CFG, 6'd1, {46'd0, cfg_byte(1'b1, A_NAPOT, 3'd5)}, '0, '0, 1'b0);
        send_word(OP_WR_ADDR, 6'd1, 54'h300FF, '0, '0, 1'b0);
        check_access(56'hC0000, 3'd4, 1'b1);
        check_access(56'hC07F8, 3'd4, 1'b1);
        check_access(56'hC07F8, 3'd3, 1'b1);
        check_access(56'hC0000, 3'd7, 1'b0);
    endtask

    // Unused op, out-of-range entries, TOR entry with junk above the config byte
    task automatic test_ignored_items();
        send_word(OP_UNUSED, 6'd2, '1, '1, 3'd7, 1'b1);
        send_word(OP_WR_CFG, 6'd63, {46'd0, cfg_byte(1'b1, A_NAPOT, 3'd7)}, '0, '0, 1'b0);
        send_word(OP_WR_ADDR, 6'd16, '1, '0, '0, 1'b0);
        send_word(OP_WR_CFG, 6'd2, {46'h3FFF_FFFF_FFFF, cfg_byte(1'b0, A_TOR, 3'd7)},
                  '0, '0, 1'b0);
        send_word(OP_WR_ADDR, 6'd2, '1, '0, '0, 1'b0);
        check_access('0, 3'd0, 1'b0);
    endtask

    // All-ones word covers the whole space; last byte wraps past the top
    task automatic test_wrap_full_space();
        send_word(OP_WR_CFG, 6'd3, {46'd0, cfg_byte(1'b1, A_NAPOT, 3'd6)}, '0, '0, 1'b0);
        send_word(OP_WR_ADDR, 6'd3, '1, '0, '0, 1'b0);
        check_access('1, 3'd4, 1'b1);
        check_access('0, 3'd0, 1'b0);
    endtask

    // Mostly checks, many aimed at region edges, plus table writes and some noise
    task automatic run_random_traffic(int n_items);
        int kind;
        int k;
        int j;
        logic [ENTRY_W-1:0] ent;
        logic [VALUE_W-1:0] val;
        logic [1:0] amode;
        logic [63:0] word;
        logic [63:0] ones;
        logic [63:0] base;
        logic [63:0] len;
        logic [63:0] a;
        logic [SIZE_W-1:0] sz;
        for (int n = 0; n < n_items; n++) begin
            kind = $urandom_range(99);
            ent = ($urandom_range(99) < 85) ? ENTRY_W'($urandom_range(NUM_ENT - 1))
                                            : ENTRY_W'($urandom_range(63));
            val = VALUE_W'({$urandom, $urandom});
            if (kind < 12) begin
                amode = ($urandom_range(9) < 8) ? ($urandom_range(1) ? A_NAPOT : A_NA4)
                                                : 2'($urandom_range(3));
                if ($urandom_range(3) != 0) val = '0;
                val[7:0] = cfg_byte(1'($urandom_range(1)), amode, 3'($urandom_range(7)));
                val[6:5] = 2'($urandom_range(3));
                send_word(OP_WR_CFG, ent, val, PADDR_IN_W'({$urandom, $urandom}),
                          SIZE_W'($urandom_range(7)), 1'($urandom_range(1)));
            end else if (kind < 24) begin
                // trailing ones set the region size; mostly small regions
                k = ($urandom_range(3) == 0) ? $urandom_range(53) : $urandom_range(12);
                val = (val << (k + 1)) | ((54'd1 << k) - 54'd1);
                if ($urandom_range(19) == 0) val = '1;
                send_word(OP_WR_ADDR, ent, val, '0, SIZE_W'($urandom_range(7)),
                          1'($urandom_range(1)));
            end else if (kind < 27) begin
                send_word(OP_UNUSED, ent, val, PADDR_IN_W'({$urandom, $urandom}),
                          SIZE_W'($urandom_range(7)), 1'($urandom_range(1)));
            end else begin
                sz = ($urandom_range(99) < 85) ? SIZE_W'($urandom_range(4))
                                               : SIZE_W'($urandom_range(7, 5));
                if ($urandom_range(99) < 30) begin
                    a = {$urandom, $urandom};
                end else begin
                    j = $urandom_range(NUM_ENT - 1);
                    word = {10'd0, pmp_addr_tbl[j]};
                    if (pmp_cfg_tbl[j][CFG_A_LSB +: 2] == A_NA4) begin
                        base = word << 2;
                        len = 64'd4;
                    end else begin
                        ones = word ^ (word + 64'd1);
                        base = (word & ~ones) << 2;
                        len = ((ones << 2) | 64'd3) + 64'd1;
                    end
                    a = ($urandom_range(1) ? base : base + len)
                        + 64'($urandom_range(32)) - 64'd16;
                end
                check_access(a[PADDR_IN_W-1:0], sz, 1'($urandom_range(1)));
            end
        end
    endtask

    initial begin
        for (int i = 0; i < NUM_ENT; i++) begin
            pmp_cfg_tbl[i] = '0;
            pmp_addr_tbl[i] = '0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_na4_region();
        test_napot_locked();
        test_ignored_items();
        test_wrap_full_space();

        send_idle_pct = 34;
        recv_idle_pct = 86;
        run_random_traffic(170);
        send_idle_pct = 86;
        recv_idle_pct = 34;
        run_random_traffic(170);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random_traffic(170);

        // drop valid, drain, then watch for stray words
        s_tvalid <= 1'b0;
        while (exp_perm_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_cnt == 0 && exp_perm_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
